### rtl/core/srcp_pkg.sv
// ----------------------------------------------------------------------------
// srcp_pkg
// Shared types and constants of the sensor report command parser: event
// codes, command text table and the line match result bundle.
// ----------------------------------------------------------------------------
package srcp_pkg;

  // Result event codes
  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_REPORT   = 4'd1,
    EV_STOP     = 4'd2,
    EV_START    = 4'd3,
    EV_OFF      = 4'd4,
    EV_SCALE_F  = 4'd5,
    EV_SCALE_C  = 4'd6,
    EV_PERIOD   = 4'd7,
    EV_LOG      = 4'd8,
    EV_BAD      = 4'd9,
    EV_TOO_LONG = 4'd10,
    EV_HALTED   = 4'd11
  } event_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_PERIOD = 2'd0;
  localparam logic [1:0] CFG_START_SCALE  = 2'd1;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CFG_W    = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = '1;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  // Command candidates, in match priority order
  localparam int unsigned NCAND       = 7;
  localparam int unsigned CAND_PERIOD = 5;

  // Texts left-justified in seven characters; only the first CAND_LEN count
  localparam logic [55:0] CAND_TEXT [NCAND] = '{
    "STOP   ", "START  ", "OFF    ", "SCALE=F", "SCALE=C", "PERIOD=", "LOG    "
  };
  localparam logic [2:0] CAND_LEN [NCAND] = '{
    3'd4, 3'd5, 3'd3, 3'd7, 3'd7, 3'd7, 3'd3
  };
  // PERIOD= and LOG accept any tail
  localparam logic [NCAND-1:0] CAND_PREFIX = 7'b110_0000;
  localparam event_t CAND_EVENT [NCAND] = '{
    EV_STOP, EV_START, EV_OFF, EV_SCALE_F, EV_SCALE_C, EV_PERIOD, EV_LOG
  };

  // Character at a position of a candidate text
  function automatic logic [7:0] cand_char(input int unsigned idx, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (pos <= 3'd6) begin
      ch = CAND_TEXT[idx][8*(6-int'(pos)) +: 8];
    end
    return ch;
  endfunction

  // Outcome of one command byte
  typedef struct packed {
    event_t              evt;
    logic [PERIOD_W-1:0] period_val;
  } line_res_t;

endpackage

### rtl/core/srcp_if.sv
// ----------------------------------------------------------------------------
// srcp_in_if / srcp_out_if
// Valid/ready channels of the parser: command bytes and ticks in, one
// result per item out.
// ----------------------------------------------------------------------------
interface srcp_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface srcp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic        reporting_on;
  logic        scale_celsius;
  logic [15:0] period_now;

  modport source (
    output valid, output event_res, output reporting_on,
    output scale_celsius, output period_now, input ready
  );
  modport sink (
    input valid, input event_res, input reporting_on,
    input scale_celsius, input period_now, output ready
  );
endinterface

### rtl/core/srcp_line_match.sv
// ----------------------------------------------------------------------------
// srcp_line_match
// Incremental command line matcher: tracks line length, the set of still
// possible commands and the PERIOD= digit run, and names the command at
// the newline.
// ----------------------------------------------------------------------------
module srcp_line_match #(
  parameter int unsigned LINE_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  output srcp_pkg::line_res_t res
);
  import srcp_pkg::*;

  localparam int unsigned LEN_W = $clog2(LINE_BYTES);
  localparam logic [LEN_W-1:0] LEN_LIMIT  = LEN_W'(LINE_BYTES - 1);
  localparam logic [LEN_W-1:0] DIGIT_POS  = LEN_W'(CAND_LEN[CAND_PERIOD]);

  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [NCAND-1:0]    flags_r, flags_nxt;
  logic [PERIOD_W-1:0] num_r, num_nxt;
  logic                ended_r, ended_nxt;

  logic [NCAND-1:0]    flags_upd;
  logic [PERIOD_W+3:0] num_x10;
  logic                is_digit;
  logic                too_long;
  logic                found;
  event_t              end_evt;

  // Narrow candidates by the byte at this position
  always_comb begin
    flags_upd = flags_r;
    for (int unsigned i = 0; i < NCAND; i++) begin
      if (len_r < LEN_W'(CAND_LEN[i])) begin
        if (cand_char(i, len_r[2:0]) != rx_byte) begin
          flags_upd[i] = 1'b0;
        end
      end else if (!CAND_PREFIX[i]) begin
        flags_upd[i] = 1'b0;
      end
    end
  end

  // Pick the command named by the finished line
  always_comb begin
    found   = 1'b0;
    end_evt = EV_BAD;
    for (int unsigned i = 0; i < NCAND; i++) begin
      if (!found && flags_r[i]) begin
        if (CAND_PREFIX[i] ? (len_r >= LEN_W'(CAND_LEN[i]))
                           : (len_r == LEN_W'(CAND_LEN[i]))) begin
          found   = 1'b1;
          end_evt = CAND_EVENT[i];
        end
      end
    end
  end

  assign too_long = (len_r >= LEN_LIMIT);
  assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
  assign num_x10  = ({4'd0, num_r} << 3) + ({4'd0, num_r} << 1)
                  + {12'd0, rx_byte[3:0]};

  // Advance line state and form the event
  always_comb begin
    len_nxt        = len_r;
    flags_nxt      = flags_r;
    num_nxt        = num_r;
    ended_nxt      = ended_r;
    res.evt        = EV_NONE;
    res.period_val = num_r;
    priority if (rx_byte == CHAR_NEWLINE) begin
      res.evt   = end_evt;
      len_nxt   = '0;
      flags_nxt = '1;
      num_nxt   = '0;
      ended_nxt = 1'b0;
    end else if (too_long) begin
      res.evt = EV_TOO_LONG;
    end else begin
      flags_nxt = flags_upd;
      len_nxt   = len_r + LEN_W'(1);
      if (flags_upd[CAND_PERIOD] && (len_r >= DIGIT_POS) && !ended_r) begin
        if (is_digit) begin
          num_nxt = (num_x10 > {4'd0, PERIOD_MAX}) ? PERIOD_MAX : num_x10[PERIOD_W-1:0];
        end else begin
          ended_nxt = 1'b1;
        end
      end
    end
  end

  // Hold line state between bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      flags_r <= '1;
      num_r   <= '0;
      ended_r <= 1'b0;
    end else if (take) begin
      len_r   <= len_nxt;
      flags_r <= flags_nxt;
      num_r   <= num_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

### rtl/core/srcp_timer.sv
// ----------------------------------------------------------------------------
// srcp_timer
// Saturating count of elapsed seconds; flags a report when the count
// reaches the period while reporting is on, and clears the count.
// ----------------------------------------------------------------------------
module srcp_timer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          tick,
  input  logic                          reporting,
  input  logic [srcp_pkg::PERIOD_W-1:0] period,
  output logic                          report
);
  import srcp_pkg::*;

  logic [PERIOD_W-1:0] elapsed_r, elapsed_nxt;
  logic [PERIOD_W-1:0] elapsed_inc;

  assign elapsed_inc = (elapsed_r != PERIOD_MAX) ? elapsed_r + PERIOD_W'(1) : elapsed_r;
  assign report      = reporting && (elapsed_inc >= period);
  assign elapsed_nxt = report ? '0 : elapsed_inc;

  // Count ticks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else if (tick) begin
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

### rtl/core/sensor_report_command_parser.sv
// ----------------------------------------------------------------------------
// sensor_report_command_parser
// Command line parser and report timer of a temperature sensor node.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per transfer: mode 0 is a received command byte,
//   mode 1 a one-second tick. Every item gives exactly one result on out_ch:
//   an event code plus the reporting flag, scale and period after the item.
//   cfg_we/cfg_index/cfg_wdata load the start period (index 0) and start
//   scale (index 1); a write also loads the working value at once. Write
//   only while no item is in flight.
// Latency and throughput:
//   One item per cycle while out_ch takes results. The result sits in the
//   output register the cycle after the input transfer; all work is one
//   combinational pass from the input handshake into that register.
// Reset:
//   Synchronous, active low. Period returns to 1, scale to Fahrenheit,
//   reporting on, line and elapsed count cleared, halt flag cleared.
// Stall:
//   While a result waits in the output register and out_ch.ready is low,
//   in_ch.ready drops; nothing is lost. A waiting result is replaced in the
//   same cycle it is taken.
// ----------------------------------------------------------------------------
module sensor_report_command_parser #(
  parameter int unsigned LINE_BYTES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  srcp_in_if.sink                    in_ch,
  srcp_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [srcp_pkg::CFG_W-1:0] cfg_wdata
);
  import srcp_pkg::*;

  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic                scale_r, scale_nxt;
  logic                reporting_r, reporting_nxt;
  logic                halted_r, halted_nxt;

  logic                out_valid_r;
  event_t              out_evt_r;
  logic                out_rep_r;
  logic                out_scale_r;
  logic [PERIOD_W-1:0] out_period_r;

  logic      accept;
  logic      take_byte;
  logic      take_tick;
  logic      report;
  event_t    evt;
  line_res_t line_res;

  // Accept whenever the output register is free or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign take_byte   = accept && !halted_r && !in_ch.mode;
  assign take_tick   = accept && !halted_r && in_ch.mode;

  srcp_line_match #(
    .LINE_BYTES (LINE_BYTES)
  ) u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take_byte),
    .rx_byte (in_ch.rx_byte),
    .res     (line_res)
  );

  srcp_timer u_timer (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (take_tick),
    .reporting (reporting_r),
    .period    (period_r),
    .report    (report)
  );

  // Apply the item to the control flags
  always_comb begin
    period_nxt    = period_r;
    scale_nxt     = scale_r;
    reporting_nxt = reporting_r;
    halted_nxt    = halted_r;
    evt           = EV_NONE;
    priority if (halted_r) begin
      evt = EV_HALTED;
    end else if (in_ch.mode) begin
      evt = report ? EV_REPORT : EV_NONE;
    end else begin
      evt = line_res.evt;
      unique case (line_res.evt)
        EV_STOP:     reporting_nxt = 1'b0;
        EV_START:    reporting_nxt = 1'b1;
        EV_SCALE_F:  scale_nxt     = 1'b0;
        EV_SCALE_C:  scale_nxt     = 1'b1;
        EV_PERIOD:   period_nxt    = line_res.period_val;
        EV_OFF, EV_BAD, EV_TOO_LONG: halted_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  // Hold control state; configuration writes load the working values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RESET;
      scale_r     <= 1'b0;
      reporting_r <= 1'b1;
      halted_r    <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_START_PERIOD) begin
        period_r <= cfg_wdata[PERIOD_W-1:0];
      end else if (cfg_index == CFG_START_SCALE) begin
        scale_r <= cfg_wdata[0];
      end
    end else if (accept) begin
      period_r    <= period_nxt;
      scale_r     <= scale_nxt;
      reporting_r <= reporting_nxt;
      halted_r    <= halted_nxt;
    end
  end

  // Output register: valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_evt_r    <= evt;
      out_rep_r    <= reporting_nxt;
      out_scale_r  <= scale_nxt;
      out_period_r <= period_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_res     = out_evt_r;
  assign out_ch.reporting_on  = out_rep_r;
  assign out_ch.scale_celsius = out_scale_r;
  assign out_ch.period_now    = out_period_r;

endmodule

### rtl/core/srcp_checker.sv
// ----------------------------------------------------------------------------
// srcp_checker
// Port-level checks of the parser result stream, bound to the top level.
// ----------------------------------------------------------------------------
module srcp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_event_res,
  input logic       out_reporting_on
);
  import srcp_pkg::*;

  logic halted_seen_r;

  // Remember a transfer that halts the block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_seen_r <= 1'b0;
    end else if (out_valid && out_ready &&
                 (out_event_res == EV_OFF || out_event_res == EV_BAD ||
                  out_event_res == EV_TOO_LONG || out_event_res == EV_HALTED)) begin
      halted_seen_r <= 1'b1;
    end
  end

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_res <= EV_HALTED)
    else $error("event code out of range");

  a_stay_halted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && halted_seen_r |-> out_event_res == EV_HALTED)
    else $error("activity after halt");

  a_report_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_REPORT || out_event_res == EV_START)
      |-> out_reporting_on)
    else $error("report or start with reporting off");

  a_stop_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_STOP |-> !out_reporting_on)
    else $error("stop left reporting on");

endmodule

bind sensor_report_command_parser srcp_checker u_srcp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_event_res    (out_ch.event_res),
  .out_reporting_on (out_ch.reporting_on)
);
